>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/afih_pkg.sv
// ----------------------------------------------------------------------------
// afih_pkg
// Types, constants and hash step functions of the filename ID hash.
// ----------------------------------------------------------------------------
`default_nettype none

package afih_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut  = 32'hFFFF_FFFF;
  localparam logic [7:0]  LowerA     = 8'h61;
  localparam logic [7:0]  LowerZ     = 8'h7A;
  localparam logic [7:0]  CaseOffset = 8'h20;

  // One name word as held in the input register
  typedef struct packed {
    logic [7:0] name_char;
    logic       is_last;
  } item_t;

  // Both identifiers of one name
  typedef struct packed {
    logic [31:0] crc_id;
    logic [31:0] classic_id;
  } result_t;

  // Upper-case ASCII a..z, pass all else
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LowerA && c <= LowerZ) begin
      r = c - CaseOffset;
    end
    return r;
  endfunction

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    end
    return r;
  endfunction

  // Rotate left by one and add
  function automatic logic [31:0] rot_add(input logic [31:0] acc, input logic [31:0] w);
    return {acc[30:0], acc[31]} + w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/afih_in_stage.sv
// ----------------------------------------------------------------------------
// afih_in_stage
// Input register: captures one name word and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module afih_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      name_char_i,
  input  wire logic            is_last_i,
  input  wire logic            out_free_i,
  output logic                 proc_o,
  output afih_pkg::item_t      item_o
);

  logic            valid_q, valid_d;
  afih_pkg::item_t item_q, item_d;
  logic            load;

  // Hand the held word on unless it is a last word and the result slot is busy
  assign proc_o     = valid_q && (!item_q.is_last || out_free_i);
  assign in_stall_o = valid_q && !proc_o;
  assign load       = !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d        = in_valid_i;
      item_d.name_char = name_char_i;
      item_d.is_last   = is_last_i;
    end
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

>>> rtl/core/afih_hash_core.sv
// ----------------------------------------------------------------------------
// afih_hash_core
// Running CRC and block state; folds one word per cycle while proc_i is set, pads on the last.
// ----------------------------------------------------------------------------
`default_nettype none

module afih_hash_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            proc_i,
  input  wire afih_pkg::item_t item_i,
  output afih_pkg::result_t    result_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] classic_q, classic_d;
  logic [31:0] word_q, word_d;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  first_q, first_d;

  logic [7:0]  c;
  logic [1:0]  pos_n;
  logic [7:0]  first_n;
  logic [31:0] word_n;
  logic [31:0] crc1, pad1, pad2, pad3, crc_fin;
  logic [31:0] classic_rot;

  // Fold the character into both hashes
  assign c       = afih_pkg::upcase(item_i.name_char);
  assign pos_n   = pos_q + 2'd1;
  assign first_n = (pos_q == 2'd0) ? c : first_q;
  assign word_n  = word_q | ({24'd0, c} << {pos_q, 3'b000});
  assign crc1    = afih_pkg::crc_byte(crc_q, c);
  assign classic_rot = afih_pkg::rot_add(classic_q, word_n);

  // Pad a partial block: length mod 4, then copies of the block's first char
  assign pad1 = afih_pkg::crc_byte(crc1, {6'd0, pos_n});
  assign pad2 = afih_pkg::crc_byte(pad1, first_n);
  assign pad3 = afih_pkg::crc_byte(pad2, first_n);

  always_comb begin
    unique case (pos_n)
      2'd1:    crc_fin = pad3;
      2'd2:    crc_fin = pad2;
      2'd3:    crc_fin = pad1;
      default: crc_fin = crc1;
    endcase
  end

  assign result_o.crc_id     = crc_fin ^ afih_pkg::CrcXorOut;
  assign result_o.classic_id = classic_rot;

  // Advance state, drop back to reset values after a name ends
  always_comb begin
    crc_d     = crc_q;
    classic_d = classic_q;
    word_d    = word_q;
    pos_d     = pos_q;
    first_d   = first_q;
    if (proc_i) begin
      if (item_i.is_last) begin
        crc_d     = afih_pkg::CrcInit;
        classic_d = 32'd0;
        word_d    = 32'd0;
        pos_d     = 2'd0;
        first_d   = 8'd0;
      end else begin
        crc_d   = crc1;
        pos_d   = pos_n;
        first_d = first_n;
        if (pos_n == 2'd0) begin
          classic_d = classic_rot;
          word_d    = 32'd0;
        end else begin
          word_d    = word_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= afih_pkg::CrcInit;
      classic_q <= 32'd0;
      word_q    <= 32'd0;
      pos_q     <= 2'd0;
      first_q   <= 8'd0;
    end else begin
      crc_q     <= crc_d;
      classic_q <= classic_d;
      word_q    <= word_d;
      pos_q     <= pos_d;
      first_q   <= first_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/archive_filename_id_hash.sv
// A name's last character waits in the input register, then its result word in the result register.
// Throughput: one character per cycle; the CRC byte step and block pack are combinational logic.
// A result waiting under stall holds back only a following last character.
// Reset: asynchronous, active low; hash state returns to all-ones CRC and zero blocks,
// input and result registers empty.
// ----------------------------------------------------------------------------
// archive_filename_id_hash
// Filename ID hash top level: input register, hash core, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_filename_id_hash (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  name_char_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      crc_id_o,
  output logic [31:0]      classic_id_o
);

  afih_pkg::item_t   item;
  afih_pkg::result_t result;
  afih_pkg::result_t res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              proc;

  assign out_free = !out_valid_q || !out_stall_i;

  afih_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .name_char_i (name_char_i),
    .is_last_i   (is_last_i),
    .out_free_i  (out_free),
    .proc_o      (proc),
    .item_o      (item)
  );

  afih_hash_core u_hash_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_i   (proc),
    .item_i   (item),
    .result_o (result)
  );

  // Load a finished result, clear the slot once the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (proc && item.is_last) begin
      out_valid_d = 1'b1;
      res_d       = result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign crc_id_o     = res_q.crc_id;
  assign classic_id_o = res_q.classic_id;

endmodule

`default_nettype wire

>>> rtl/core/afih_checker.sv
// ----------------------------------------------------------------------------
// afih_checker
// Port-level checks of the filename ID hash, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module afih_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] crc_id_o,
  input wire logic [31:0] classic_id_o
);

  // A stalled result word holds
  `ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
              out_valid_o && $stable(crc_id_o) && $stable(classic_id_o),
              "result word changed under stall")

  // Input back-pressure only comes from a blocked result slot
  `ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
              "input stalled with free result slot")

  // A fresh result needs a word accepted or held at the input before the input and result registers
  `ASSERT_IMP(a_out_source, $rose(out_valid_o),
              $past(in_valid_i, 2) || $past(in_stall_o, 2),
              "result without input word")

endmodule

bind archive_filename_id_hash afih_checker u_afih_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .crc_id_o     (crc_id_o),
  .classic_id_o (classic_id_o)
);

`default_nettype wire

>>> tb/afih_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afih_tb_checker
// Watches both channels of the filename ID hash. Runs its own model of the
// CRC and rotate-add hashes on every accepted character word, and queues the
// two IDs at each last character. Compares every accepted result word, field
// by field, with the oldest queued pair. Hands the mismatch count and the
// number of pairs still waiting to the testbench top.
// ----------------------------------------------------------------------------

module afih_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  name_char_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] crc_id_i,
  input  logic [31:0] classic_id_i,
  output int          mismatch_count_o,
  output int          ids_pending_o
);

  // Model state for the name in progress
  logic [31:0] crc_reg;
  logic [31:0] classic_reg;
  logic [31:0] block_bytes;
  logic [1:0]  block_fill;
  logic [7:0]  block_lead;

  afih_pkg::result_t expected_ids[$];
  afih_pkg::result_t seen_ids;
  afih_pkg::result_t due_ids;
  int                mismatches = 0;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= afih_pkg::LowerA && c <= afih_pkg::LowerZ) begin
      return c - afih_pkg::CaseOffset;
    end
    return c;
  endfunction

  // Shift one byte through the reflected CRC, LSB first
  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] acc;
    acc = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ afih_pkg::CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [31:0] rotate_add(input logic [31:0] acc, input logic [31:0] blk);
    return ((acc << 1) | (acc >> 31)) + blk;
  endfunction

  function automatic void clear_name();
    crc_reg     = afih_pkg::CrcInit;
    classic_reg = '0;
    block_bytes = '0;
    block_fill  = '0;
    block_lead  = '0;
  endfunction

  // Fold one character word into the model; queue both IDs on the last one
  function automatic void absorb_char(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    c = to_upper(raw);
    if (block_fill == 2'd0) begin
      block_lead = c;
    end
    crc_reg     = fold_byte(crc_reg, c);
    block_bytes = block_bytes | ({24'd0, c} << (8 * int'(block_fill)));
    block_fill  = block_fill + 2'd1;
    if (block_fill == 2'd0) begin
      classic_reg = rotate_add(classic_reg, block_bytes);
      block_bytes = '0;
    end
    if (last) begin
      // Pad a partial block: its length, then copies of its first character
      if (block_fill != 2'd0) begin
        crc_reg = fold_byte(crc_reg, {6'd0, block_fill});
        for (int k = 0; k < 3 - int'(block_fill); k++) begin
          crc_reg = fold_byte(crc_reg, block_lead);
        end
        classic_reg = rotate_add(classic_reg, block_bytes);
      end
      expected_ids.push_back('{crc_id: crc_reg ^ afih_pkg::CrcXorOut,
                               classic_id: classic_reg});
      clear_name();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_name();
      mismatch_count_o <= 0;
      ids_pending_o    <= 0;
    end else begin
      // Compare the accepted result word with the oldest pair
      if (out_valid_i && !out_stall_i) begin
        seen_ids.crc_id     = crc_id_i;
        seen_ids.classic_id = classic_id_i;
        if (expected_ids.size() == 0) begin
          $error("result word with nothing expected: crc_id %h classic_id %h",
                 seen_ids.crc_id, seen_ids.classic_id);
          mismatches++;
        end else begin
          due_ids = expected_ids.pop_front();
          if (seen_ids.crc_id !== due_ids.crc_id) begin
            $error("crc_id mismatch: expected %h, actual %h",
                   due_ids.crc_id, seen_ids.crc_id);
            mismatches++;
          end
          if (seen_ids.classic_id !== due_ids.classic_id) begin
            $error("classic_id mismatch: expected %h, actual %h",
                   due_ids.classic_id, seen_ids.classic_id);
            mismatches++;
          end
        end
      end
      // Advance the model on an accepted character word
      if (in_valid_i && !in_stall_i) begin
        absorb_char(name_char_i, is_last_i);
      end
      mismatch_count_o <= mismatches;
      ids_pending_o    <= expected_ids.size();
    end
  end

endmodule

>>> tb/archive_filename_id_hash_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// archive_filename_id_hash_tb
// Feeds filenames one character word at a time: a short directed set over
// the case-folding edges and every partial-block length, then random names
// in phases of sender gaps and receiver stalls. The checker beside the block
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------

module archive_filename_id_hash_tb;

  localparam int NameChars  = 650;
  localparam int PhaseChars = 160;

  // Directed names as {last, character}
  localparam logic [8:0] DirectedChars [21] = '{
    9'h1_61,
    9'h0_7A, 9'h1_7B,
    9'h0_60, 9'h0_00, 9'h1_FF,
    9'h0_80, 9'h0_41, 9'h0_5A, 9'h1_7F,
    9'h0_61, 9'h0_62, 9'h0_63, 9'h0_64, 9'h1_7A,
    9'h0_40, 9'h0_5B, 9'h0_20, 9'h0_7E, 9'h0_71, 9'h1_2E
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  name_char  = 8'd0;
  logic        is_last    = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] crc_id;
  logic [31:0] classic_id;

  int mismatch_count;
  int ids_pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int chars_sent = 0;

  archive_filename_id_hash u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .name_char_i  (name_char),
    .is_last_i    (is_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .crc_id_o     (crc_id),
    .classic_id_o (classic_id)
  );

  afih_tb_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .name_char_i      (name_char),
    .is_last_i        (is_last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .crc_id_i         (crc_id),
    .classic_id_i     (classic_id),
    .mismatch_count_o (mismatch_count),
    .ids_pending_o    (ids_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("archive_filename_id_hash test failed");
    $finish;
  end

  // Hold the word until it is taken, after a random gap
  task automatic push_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    name_char <= c;
    is_last   <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    chars_sent++;
  endtask

  function automatic int LowerOffset();
    return int'(afih_pkg::LowerA);
  endfunction

  // Mostly lower-case letters, some printable, some any byte
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(9);
    if (r < 5) begin
      return 8'(LowerOffset() + $urandom_range(25));
    end else if (r < 7) begin
      return 8'($urandom_range(8'h7E, 8'h20));
    end
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int len;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed names over the case edges and each block remainder
    foreach (DirectedChars[i]) begin
      push_char(DirectedChars[i][7:0], DirectedChars[i][8]);
    end

    // Random names, phase by phase
    while (chars_sent < NameChars) begin
      phase = (chars_sent / PhaseChars) % 4;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        push_char(pick_char(), k == len - 1);
      end
    end
    in_valid  <= 1'b0;
    stall_pct = 0;

    // Drain the result channel, then allow for the pipeline
    while (ids_pending != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && ids_pending == 0) begin
      $display("archive_filename_id_hash test passed");
    end else begin
      $display("archive_filename_id_hash test failed");
    end
    $finish;
  end

endmodule
